/* rtl/jse_pkg.sv */
package jse_pkg;

  localparam int CODE_W  = 21;
  localparam int CHAR_W  = 16;
  localparam int RUN_MAX = 6;
  localparam int LEN_W   = 3;

  localparam logic [CHAR_W-1:0] BMP_MAX = 16'hFFFF;

  localparam logic [CHAR_W-1:0] CH_BS      = 16'h0008;
  localparam logic [CHAR_W-1:0] CH_TAB     = 16'h0009;
  localparam logic [CHAR_W-1:0] CH_LF      = 16'h000A;
  localparam logic [CHAR_W-1:0] CH_FF      = 16'h000C;
  localparam logic [CHAR_W-1:0] CH_CR      = 16'h000D;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 16'h0020;
  localparam logic [CHAR_W-1:0] CH_BANG    = 16'h0021;
  localparam logic [CHAR_W-1:0] CH_QUOTE   = 16'h0022;
  localparam logic [CHAR_W-1:0] CH_HASH    = 16'h0023;
  localparam logic [CHAR_W-1:0] CH_PERIOD  = 16'h002E;
  localparam logic [CHAR_W-1:0] CH_SLASH   = 16'h002F;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 16'h0030;
  localparam logic [CHAR_W-1:0] CH_LBRACK  = 16'h005B;
  localparam logic [CHAR_W-1:0] CH_BSLASH  = 16'h005C;
  localparam logic [CHAR_W-1:0] CH_RBRACK  = 16'h005D;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 16'h0041;
  localparam logic [CHAR_W-1:0] CH_B       = 16'h0062;
  localparam logic [CHAR_W-1:0] CH_F       = 16'h0066;
  localparam logic [CHAR_W-1:0] CH_N       = 16'h006E;
  localparam logic [CHAR_W-1:0] CH_R       = 16'h0072;
  localparam logic [CHAR_W-1:0] CH_T       = 16'h0074;
  localparam logic [CHAR_W-1:0] CH_U       = 16'h0075;

  localparam logic [LEN_W-1:0] LEN_PLAIN = 3'd1;
  localparam logic [LEN_W-1:0] LEN_SHORT = 3'd2;
  localparam logic [LEN_W-1:0] LEN_UNI   = 3'd6;

  typedef logic [RUN_MAX-1:0][CHAR_W-1:0] run_chars_t;

  typedef struct packed {
    run_chars_t       chars;
    logic [LEN_W-1:0] len;
  } run_t;

  typedef struct packed {
    logic can_load;
  } buf_status_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] r;
    if (nib < 4'd10) begin
      r = CH_ZERO + CHAR_W'(nib);
    end else begin
      r = CH_UPPER_A + CHAR_W'(nib - 4'd10);
    end
    return r;
  endfunction

endpackage

/* rtl/jse_escape.sv */
module jse_escape (
  input  logic [jse_pkg::CODE_W-1:0] code,
  output jse_pkg::run_t              run
);
  import jse_pkg::*;

  logic              in_bmp;
  logic [CHAR_W-1:0] c16;
  logic [CHAR_W-1:0] sat;
  logic              pass;
  logic [CHAR_W-1:0] letter;
  logic              has_letter;

  assign in_bmp = (code[CODE_W-1:CHAR_W] == '0);
  assign c16    = code[CHAR_W-1:0];
  assign sat    = in_bmp ? c16 : BMP_MAX;

  assign pass = in_bmp && ((c16 == CH_SPACE) || (c16 == CH_BANG) ||
                ((c16 >= CH_HASH) && (c16 <= CH_PERIOD)) ||
                ((c16 >= CH_ZERO) && (c16 <= CH_LBRACK)) ||
                (c16 >= CH_RBRACK));

  always_comb begin
    has_letter = in_bmp;
    letter     = '0;
    case (c16)
      CH_BS:     letter = CH_B;
      CH_FF:     letter = CH_F;
      CH_LF:     letter = CH_N;
      CH_CR:     letter = CH_R;
      CH_TAB:    letter = CH_T;
      CH_SLASH:  letter = CH_SLASH;
      CH_QUOTE:  letter = CH_QUOTE;
      CH_BSLASH: letter = CH_BSLASH;
      default:   has_letter = 1'b0;
    endcase
  end

  always_comb begin
    run.chars = '0;
    if (pass) begin
      run.chars[0] = c16;
      run.len      = LEN_PLAIN;
    end else if (has_letter) begin
      run.chars[0] = CH_BSLASH;
      run.chars[1] = letter;
      run.len      = LEN_SHORT;
    end else begin
      run.chars[0] = CH_BSLASH;
      run.chars[1] = CH_U;
      run.chars[2] = hex_char(sat[15:12]);
      run.chars[3] = hex_char(sat[11:8]);
      run.chars[4] = hex_char(sat[7:4]);
      run.chars[5] = hex_char(sat[3:0]);
      run.len      = LEN_UNI;
    end
  end

endmodule

/* rtl/jse_run_buffer.sv */
module jse_run_buffer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  jse_pkg::run_t              run,
  input  logic                       run_end,
  output jse_pkg::buf_status_t       status,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [jse_pkg::CHAR_W-1:0] m_tdata,  // out_char
  output logic                       m_tlast,  // out_string_end
  output logic                       m_tuser   // run_last
);
  import jse_pkg::*;

  run_chars_t       chars;
  logic [LEN_W-1:0] remain;
  logic             valid;
  logic             end_flag;
  logic             xfer;
  logic             final_char;

  assign final_char      = (remain == LEN_W'(1));
  assign xfer            = valid && m_tready;
  assign status.can_load = !valid || (xfer && final_char);

  assign m_tvalid = valid;
  assign m_tdata  = chars[0];
  assign m_tuser  = final_char;
  assign m_tlast  = final_char && end_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= 1'b0;
      remain <= '0;
    end else if (load) begin
      valid  <= 1'b1;
      remain <= run.len;
    end else if (xfer) begin
      valid  <= !final_char;
      remain <= remain - LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chars    <= run.chars;
      end_flag <= run_end;
    end else if (xfer) begin
      chars <= {CHAR_W'(0), chars[RUN_MAX-1:1]};
    end
  end

endmodule

/* rtl/json_string_escaper_top.sv */
// JSON string escaper. Each transfer on the s side carries one code point and
// an end-of-string flag in tlast; the m side returns its escaped form one
// 16-bit character per transfer, with tuser high on the last character of
// each run and tlast high on the last character of the string's final run.
// Plain characters leave at one per cycle while m_tready is high; a short
// escape is two characters and a \uXXXX escape six, shifted out by the output
// run buffer at one character per cycle while m_tready is high. Code points
// above 0xFFFF come out as \uFFFF. An input transfer is held in an input
// register, then escape-decoded into the run buffer that drives the m side.
module json_string_escaper_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // in_char[20:0], zero pad
  input  logic        s_tlast,   // in_string_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // out_char
  output logic        m_tlast,   // out_string_end
  output logic        m_tuser    // run_last
);
  import jse_pkg::*;

  logic              in_valid;
  logic [CODE_W-1:0] in_char;
  logic              in_end;
  logic              s_xfer;
  logic              load;
  run_t              run;
  buf_status_t       status;

  assign s_xfer   = s_tvalid && s_tready;
  assign load     = in_valid && status.can_load;
  assign s_tready = !in_valid || status.can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_xfer) begin
      in_valid <= 1'b1;
    end else if (load) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      in_char <= s_tdata[CODE_W-1:0];
      in_end  <= s_tlast;
    end
  end

  jse_escape u_escape (
    .code (in_char),
    .run  (run)
  );

  jse_run_buffer u_run_buffer (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .run      (run),
    .run_end  (in_end),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

/* sim/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import jse_pkg::*;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              run_last;
    logic              str_end;
  } esc_char_t;

  class escape_checker;
    esc_char_t pending_chars[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    function logic [CHAR_W-1:0] hex_glyph(input logic [3:0] nib);
      logic [CHAR_W-1:0] g;
      if (nib > 4'd9) begin
        g = CH_UPPER_A - 16'd10 + {12'd0, nib};
      end else begin
        g = CH_ZERO + {12'd0, nib};
      end
      return g;
    endfunction

    // expand one code point into its escaped run and queue the characters
    function void add_char(input logic [CODE_W-1:0] code, input logic fin);
      logic [CHAR_W-1:0] run [RUN_MAX];
      logic [CHAR_W-1:0] letter;
      logic [CHAR_W-1:0] sat;
      logic              bmp;
      int                n;
      esc_char_t         e;
      bmp    = (code[CODE_W-1:CHAR_W] == '0);
      letter = '0;
      if (bmp) begin
        case (code[CHAR_W-1:0])
          CH_BS:     letter = CH_B;
          CH_FF:     letter = CH_F;
          CH_LF:     letter = CH_N;
          CH_CR:     letter = CH_R;
          CH_TAB:    letter = CH_T;
          CH_SLASH:  letter = CH_SLASH;
          CH_QUOTE:  letter = CH_QUOTE;
          CH_BSLASH: letter = CH_BSLASH;
          default:   letter = '0;
        endcase
      end
      if (bmp && code[CHAR_W-1:0] >= CH_SPACE && code[CHAR_W-1:0] != CH_QUOTE &&
          code[CHAR_W-1:0] != CH_SLASH && code[CHAR_W-1:0] != CH_BSLASH) begin
        run[0] = code[CHAR_W-1:0];
        n = 1;
      end else if (letter != '0) begin
        run[0] = CH_BSLASH;
        run[1] = letter;
        n = 2;
      end else begin
        sat = bmp ? code[CHAR_W-1:0] : BMP_MAX;
        run[0] = CH_BSLASH;
        run[1] = CH_U;
        run[2] = hex_glyph(sat[15:12]);
        run[3] = hex_glyph(sat[11:8]);
        run[4] = hex_glyph(sat[7:4]);
        run[5] = hex_glyph(sat[3:0]);
        n = 6;
      end
      for (int k = 0; k < n; k++) begin
        e.ch       = run[k];
        e.run_last = (k == n - 1);
        e.str_end  = (k == n - 1) ? fin : 1'b0;
        pending_chars.push_back(e);
      end
    endfunction

    function void check_char(input logic [CHAR_W-1:0] ch, input logic run_last,
                             input logic str_end);
      esc_char_t e;
      if (pending_chars.size() == 0) begin
        $error("unexpected output character %h", ch);
        errors++;
        return;
      end
      e = pending_chars.pop_front();
      if (ch !== e.ch) begin
        $error("out_char: expected %h, got %h", e.ch, ch);
        errors++;
      end
      if (run_last !== e.run_last) begin
        $error("run_last: expected %b, got %b", e.run_last, run_last);
        errors++;
      end
      if (str_end !== e.str_end) begin
        $error("out_string_end: expected %b, got %b", e.str_end, str_end);
        errors++;
      end
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // in_char[20:0], zero pad
  logic        s_tlast;   // in_string_end
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // out_char
  logic        m_tlast;   // out_string_end
  logic        m_tuser;   // run_last

  escape_checker chk;
  bit            quiet;
  bit            hold_go;

  logic [CODE_W-1:0] corner_codes [23] = '{
    21'h000000, 21'h00001F, 21'h000020, 21'h000021, 21'h000022, 21'h000023,
    21'h00002E, 21'h00002F, 21'h000030, 21'h00005B, 21'h00005C, 21'h00005D,
    21'h000008, 21'h000009, 21'h00000A, 21'h00000B, 21'h00000C, 21'h00000D,
    21'h00007F, 21'h00FFFF, 21'h010000, 21'h10FFFF, 21'h1FFFFF
  };

  json_string_escaper_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [CODE_W-1:0] random_code();
    logic [CODE_W-1:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: c = CODE_W'($urandom_range(16'h20, 16'h7E));
      4:          c = CODE_W'($urandom_range(0, 16'h1F));
      5: begin
        case ($urandom_range(0, 2))
          0:       c = CODE_W'(CH_QUOTE);
          1:       c = CODE_W'(CH_SLASH);
          default: c = CODE_W'(CH_BSLASH);
        endcase
      end
      6:          c = CODE_W'($urandom_range(16'h80, 16'hFFFF));
      7:          c = CODE_W'($urandom_range(21'h10000, 21'h10FFFF));
      default:    c = CODE_W'($urandom);
    endcase
    return c;
  endfunction

  // one transfer on the input side, with an occasional gap in front
  task automatic send_char(input logic [CODE_W-1:0] code, input logic fin);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, code};
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    chk.add_char(code, fin);
    @(negedge clk);
  endtask

  // output side backpressure, with one long hold to fill the block
  initial begin
    m_tready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_go) begin
        hold_go = 1'b0;
        m_tready <= 1'b0;
        repeat (80) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      chk.check_char(m_tdata, m_tuser, m_tlast);
    end
  end

  initial begin
    chk      = new();
    quiet    = 1'b0;
    hold_go  = 1'b0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 23; i++) begin
      send_char(corner_codes[i], (i % 3 == 2) || (i == 22));
    end

    hold_go = 1'b1;
    for (int i = 0; i < 360; i++) begin
      quiet = (i >= 300);
      send_char(random_code(), ($urandom_range(0, 7) == 0) || (i == 359));
    end
    s_tvalid <= 1'b0;

    while (chk.pending() != 0) @(negedge clk);
    repeat (12) @(negedge clk);

    if (chk.errors == 0 && chk.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* json_string_escaper_top.f */
rtl/jse_pkg.sv
rtl/jse_escape.sv
rtl/jse_run_buffer.sv
rtl/json_string_escaper_top.sv
sim/testbench.sv
